[design/hsbp_pkg.sv]
// Package with the shared function codes, widths and defaults of the Huffman bit packer.
package hsbp_pkg;

  localparam int WORD_BITS_DEF    = 64;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int FUNC_W  = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_IN_W = 6;
  localparam int CNT_W   = 7;
  localparam int OUT_W   = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

endpackage

[design/huffman_symbol_bit_packer.sv]
// Huffman encoder: code table memories, bit packing stage and output register.
// A word becomes valid in the output register after the encode or flush that completes it
// passes the table read, registered at accept, and then the packing stage, which holds on a full output.
// Throughput: one item per cycle; the input stalls only while a word waits unread in the
// output register and another item sits in the packing stage.
// Reset clears the length valid bits, buffer, fill count and handshake state, not the table.
module huffman_symbol_bit_packer #(
  parameter int WORD_BITS    = hsbp_pkg::WORD_BITS_DEF,
  parameter int MAX_CODE_LEN = hsbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hsbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsbp_pkg::FUNC_W-1:0]  in_func,
  input  logic [hsbp_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hsbp_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [hsbp_pkg::LEN_IN_W-1:0] in_code_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsbp_pkg::OUT_W-1:0]   out_packed_word,
  output logic [hsbp_pkg::CNT_W-1:0]   out_valid_bits,
  output logic                         out_final_word
);
  import hsbp_pkg::*;

  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CAT_W  = 2 * WORD_BITS;
  localparam logic [CNT_W-1:0] WB_L = CNT_W'(WORD_BITS);

  // Table memories, written by loads and read by every accepted item.
  logic [CODE_W-1:0]   code_mem [SYMBOL_COUNT];
  logic [LEN_IN_W-1:0] len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld_r;

  logic                in_acc;
  func_t               in_fn;
  logic                sym_ok;
  logic [ADDR_W-1:0]   in_addr;
  logic [LEN_IN_W-1:0] len_sat;

  // Packing stage.
  logic                s1_valid_r;
  func_t               s1_func_r;
  logic [CODE_W-1:0]   rd_code_r;
  logic [LEN_IN_W-1:0] rd_len_r;
  logic                rd_vld_r;
  logic                s1_adv;

  logic [WORD_BITS-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]     fill_count_r, fill_count_nxt;

  logic [CNT_W-1:0]     len_eff;
  logic [CODE_W-1:0]    code_m;
  logic [CAT_W-1:0]     cat;
  logic [CNT_W-1:0]     sum;
  logic [CNT_W-1:0]     rest;
  logic                 emit;
  logic [WORD_BITS-1:0] word;
  logic [CNT_W-1:0]     word_bits;
  logic                 word_final;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_packed_word_r;
  logic [CNT_W-1:0]     out_valid_bits_r;
  logic                 out_final_word_r;

  assign in_fn   = func_t'(in_func);
  assign in_acc  = in_valid && in_ready;
  assign sym_ok  = ({1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign in_addr = in_symbol[ADDR_W-1:0];
  assign len_sat = (CNT_W'(in_code_length) > CNT_W'(MAX_CODE_LEN)) ?
                   LEN_IN_W'(MAX_CODE_LEN) : in_code_length;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  // A load writes at its accept edge, so an encode accepted after it
  // already reads the new entry; the two never share an edge.
  always_ff @(posedge clk) begin
    if (in_acc && in_fn == FUNC_LOAD && sym_ok) begin
      code_mem[in_addr] <= in_code_bits;
      len_mem[in_addr]  <= len_sat;
    end
    if (in_acc) begin
      rd_code_r <= code_mem[in_addr];
      rd_len_r  <= len_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (in_acc && in_fn == FUNC_LOAD && sym_ok) begin
        len_vld_r[in_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= len_vld_r[in_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_func_r  <= FUNC_NONE;
    end else if (in_ready) begin
      s1_valid_r <= in_acc && ((in_fn == FUNC_ENCODE && sym_ok) || in_fn == FUNC_FLUSH);
      s1_func_r  <= in_fn;
    end
  end

  // Append the code below the pending bits; the top word is taken once the
  // total reaches a full word and the remainder stays right-aligned; a flush sends pending bits left-aligned.
  always_comb begin
    if (!rd_vld_r) begin
      len_eff = '0;
    end else if (CNT_W'(rd_len_r) > WB_L) begin
      len_eff = WB_L;
    end else begin
      len_eff = CNT_W'(rd_len_r);
    end
    code_m = rd_code_r & ~({CODE_W{1'b1}} << len_eff);
    cat    = (CAT_W'(buf_r) << len_eff) | CAT_W'(code_m);
    sum    = fill_count_r + len_eff;
    rest   = sum - WB_L;

    buf_nxt        = buf_r;
    fill_count_nxt = fill_count_r;
    emit           = 1'b0;
    word           = '0;
    word_bits      = WB_L;
    word_final     = 1'b0;

    if (s1_valid_r && s1_adv) begin
      case (s1_func_r)
        FUNC_ENCODE: begin
          if (len_eff != '0) begin
            if (sum < WB_L) begin
              buf_nxt        = WORD_BITS'(cat);
              fill_count_nxt = sum;
            end else begin
              emit           = 1'b1;
              word           = WORD_BITS'(cat >> rest);
              buf_nxt        = WORD_BITS'(cat & ~({CAT_W{1'b1}} << rest));
              fill_count_nxt = rest;
            end
          end
        end
        FUNC_FLUSH: begin
          if (fill_count_r != '0) begin
            emit           = 1'b1;
            word           = buf_r << (WB_L - fill_count_r);
            word_bits      = fill_count_r;
            word_final     = 1'b1;
            buf_nxt        = '0;
            fill_count_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r        <= '0;
      fill_count_r <= '0;
    end else begin
      buf_r        <= buf_nxt;
      fill_count_r <= fill_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_packed_word_r <= OUT_W'(word);
      out_valid_bits_r  <= word_bits;
      out_final_word_r  <= word_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_packed_word_r;
  assign out_valid_bits  = out_valid_bits_r;
  assign out_final_word  = out_final_word_r;

  a_fill_below_word: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r < WB_L)
    else $error("fill count reached a full word");

  a_full_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_final_word_r) |-> out_valid_bits_r == WB_L)
    else $error("non-final word without full bit count");

  a_final_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_final_word_r) |->
      (out_valid_bits_r != '0 && out_valid_bits_r < WB_L))
    else $error("final word with bad bit count");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_func_r == FUNC_FLUSH) |=> fill_count_r == '0)
    else $error("flush left bits pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a held word");

endmodule

[dv/huffman_symbol_bit_packer_test.sv]
// Self-checking testbench for the Huffman symbol bit packer.
`timescale 1ns / 1ps

module huffman_symbol_bit_packer_test;
  import hsbp_pkg::*;

  localparam int WORD_BITS       = WORD_BITS_DEF;
  localparam int MAX_LEN         = MAX_CODE_LEN_DEF;
  localparam int SYMBOLS         = SYMBOL_COUNT_DEF;
  localparam int RANDOM_ITEMS    = 1450;
  localparam int IDLE_PCT        = 15;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 3000;
  localparam int TAIL_CYCLES     = 10;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func        = '0;
  logic [SYM_W-1:0]    in_symbol      = '0;
  logic [CODE_W-1:0]   in_code_bits   = '0;
  logic [LEN_IN_W-1:0] in_code_length = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [OUT_W-1:0]    out_packed_word;
  logic [CNT_W-1:0]    out_valid_bits;
  logic                out_final_word;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  bit loaded [SYMBOLS];
  logic [7:0] loaded_syms [$];

  typedef struct {
    logic [OUT_W-1:0] bits;
    logic [CNT_W-1:0] count;
    logic             fin;
  } packed_word_t;

  class huffman_word_scoreboard;
    logic [CODE_W-1:0]   code_tbl [SYMBOLS];
    logic [LEN_IN_W-1:0] len_tbl  [SYMBOLS];
    logic [63:0]         pend_bits;
    int unsigned         pend_count;
    packed_word_t        words_due [$];
    int unsigned         errors;

    function new();
      foreach (len_tbl[i]) begin
        len_tbl[i]  = '0;
        code_tbl[i] = '0;
      end
      pend_bits  = '0;
      pend_count = 0;
      errors     = 0;
    endfunction

    function logic [63:0] low_ones(int unsigned n);
      return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    // Advances the packer state by one accepted item and queues any word it completes.
    function void note_item(func_t f, logic [7:0] sym, logic [31:0] bits, logic [5:0] len);
      int unsigned  n;
      int unsigned  room;
      int unsigned  rest;
      logic [63:0]  code;
      packed_word_t w;
      case (f)
        FUNC_LOAD: begin
          if (sym < SYMBOLS) begin
            code_tbl[sym] = bits;
            len_tbl[sym]  = (len > MAX_LEN) ? LEN_IN_W'(MAX_LEN) : len;
          end
        end
        FUNC_ENCODE: begin
          if (sym < SYMBOLS) begin
            n = len_tbl[sym];
            if (n > WORD_BITS) n = WORD_BITS;
            if (n != 0) begin
              code = {32'b0, code_tbl[sym]} & low_ones(n);
              room = WORD_BITS - pend_count;
              if (n < room) begin
                pend_bits  = (pend_bits << n) | code;
                pend_count = pend_count + n;
              end else begin
                // The code spills: its top bits finish this word, the rest start the next.
                rest    = n - room;
                w.bits  = ((pend_bits << room) | (code >> rest)) & low_ones(WORD_BITS);
                w.count = CNT_W'(WORD_BITS);
                w.fin   = 1'b0;
                words_due.push_back(w);
                pend_bits  = code & low_ones(rest);
                pend_count = rest;
              end
            end
          end
        end
        FUNC_FLUSH: begin
          if (pend_count != 0) begin
            w.bits  = (pend_bits << (WORD_BITS - pend_count)) & low_ones(WORD_BITS);
            w.count = CNT_W'(pend_count);
            w.fin   = 1'b1;
            words_due.push_back(w);
            pend_bits  = '0;
            pend_count = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_word(logic [OUT_W-1:0] bits, logic [CNT_W-1:0] count, logic fin);
      packed_word_t due;
      if (words_due.size() == 0) begin
        report($sformatf("word %h arrived with no word due", bits));
        return;
      end
      due = words_due.pop_front();
      if (bits !== due.bits)
        report($sformatf("packed word %h, want %h", bits, due.bits));
      if (count !== due.count)
        report($sformatf("valid bits %0d, want %0d", count, due.count));
      if (fin !== due.fin)
        report($sformatf("final flag %b, want %b", fin, due.fin));
    endtask
  endclass

  huffman_word_scoreboard sb;

  huffman_symbol_bit_packer #(
    .WORD_BITS   (WORD_BITS),
    .MAX_CODE_LEN(MAX_LEN),
    .SYMBOL_COUNT(SYMBOLS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_word(out_packed_word),
    .out_valid_bits (out_valid_bits),
    .out_final_word (out_final_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input func_t f, input logic [7:0] sym, input logic [31:0] bits,
                           input logic [5:0] len);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_symbol      <= sym;
    in_code_bits   <= bits;
    in_code_length <= len;
    do @(posedge clk); while (!in_ready);
    sb.note_item(f, sym, bits, len);
    if (f == FUNC_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Stops offering words until every word already owed has come out.
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 6'($urandom_range(1, 12));
    if (r < 95) return 6'($urandom_range(13, 32));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] any_loaded();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  // Result side: random back-pressure, plus one long hold-off when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(out_packed_word, out_valid_bits, out_final_word);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          pick;
    int          load_pct;
    func_t       f;
    logic [7:0]  sym;
    logic [31:0] bits;
    logic [5:0]  len;

    sb = new();
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturating lengths, ignored high code bits, a zero-length entry.
    send_word(FUNC_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd63);
    send_word(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd1);
    send_word(FUNC_LOAD, 8'd1, 32'h0000_0000, 6'd0);
    send_word(FUNC_LOAD, 8'd2, 32'hA5A5_A5A5, 6'd5);
    send_word(FUNC_LOAD, 8'd3, 32'h1234_5678, 6'd32);
    send_word(FUNC_LOAD, 8'd170, 32'h0000_0000, 6'd33);
    send_word(FUNC_ENCODE, 8'd1, 32'h0, 6'd0);
    send_word(FUNC_FLUSH, 8'd1, 32'h0, 6'd0);
    send_word(FUNC_NONE, 8'd255, 32'hFFFF_FFFF, 6'd63);
    send_word(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);
    send_word(FUNC_FLUSH, 8'd255, 32'h0, 6'd0);
    // Two full-length codes fill a word exactly.
    send_word(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
    send_word(FUNC_ENCODE, 8'd3, 32'h0, 6'd0);
    // A code that spills into the next word, then a short final word.
    send_word(FUNC_ENCODE, 8'd2, 32'h0, 6'd0);
    send_word(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
    send_word(FUNC_ENCODE, 8'd170, 32'h0, 6'd0);
    send_word(FUNC_FLUSH, 8'd2, 32'h0, 6'd0);
    // The longest partial word a flush can give.
    send_word(FUNC_LOAD, 8'd4, 32'h5555_5555, 6'd31);
    send_word(FUNC_ENCODE, 8'd3, 32'h0, 6'd0);
    send_word(FUNC_ENCODE, 8'd4, 32'h0, 6'd0);
    send_word(FUNC_FLUSH, 8'd4, 32'h0, 6'd0);
    // Reloading an entry with zero length removes it from the stream.
    send_word(FUNC_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    send_word(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) steady = 1'b1;
      if (i == 550) steady = 1'b0;
      if (i == 700) hold_req = 1'b1;
      if (i == 900 || i == 1200) drain_words();
      pick     = $urandom_range(0, 99);
      load_pct = (loaded_syms.size() < 24) ? 50 : 12;
      bits     = $urandom();
      if (pick < load_pct) begin
        f   = FUNC_LOAD;
        sym = 8'($urandom_range(0, 255));
        len = pick_length();
      end else begin
        // Every other kind of item names a symbol whose code has been written.
        sym = any_loaded();
        len = 6'($urandom_range(0, 63));
        if (pick < 90)
          f = FUNC_ENCODE;
        else if (pick < 97)
          f = FUNC_FLUSH;
        else
          f = FUNC_NONE;
      end
      send_word(f, sym, bits, len);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d words never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
design/hsbp_pkg.sv
design/huffman_symbol_bit_packer.sv
dv/huffman_symbol_bit_packer_test.sv
